FILE: design/hhch_pkg.sv
// Package: shared constants, types, and AES/Haraka helper functions.
package hhch_pkg;

  localparam int HeaderBytes = 140;
  localparam int RoundCount  = 5;
  localparam int NWords      = (HeaderBytes + 3) / 4;
  localparam int KeyFirst    = 108;
  localparam int KeyEnd      = 140;
  localparam int PassCount   = RoundCount * 2;
  localparam int PosW        = 6;
  localparam int PassW       = 4;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FINISH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic             load_word;
    logic [PosW-1:0]  pos;
    logic             start_comp;
    logic             do_pass;
    logic [PassW-1:0] pass_idx;
    logic             finish;
  } dp_cmd_t;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t Sbox = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants as 128-bit words, dword 0 (bytes 0..3) in bits 31:0.
  typedef logic [127:0] ktab_t [40];

  localparam ktab_t Ktab = '{
    {32'h0684704c,32'he620c00a,32'hb2c5fef0,32'h75817b9d},
    {32'h8b66b4e1,32'h88f3a06b,32'h640f6ba4,32'h2f08f717},
    {32'h3402de2d,32'h53f28498,32'hcf029d60,32'h9f029114},
    {32'h0ed6eae6,32'h2e7b4f08,32'hbbf3bcaf,32'hfd5b4f79},
    {32'hcbcfb0cb,32'h4872448b,32'h79eecd1c,32'hbe397044},
    {32'h7eeacdee,32'h6e9032b7,32'h8d5335ed,32'h2b8a057b},
    {32'h67c28f43,32'h5e2e7cd0,32'he2412761,32'hda4fef1b},
    {32'h2924d9b0,32'hafcacc07,32'h675ffde2,32'h1fc70b3b},
    {32'hab4d63f1,32'he6867fe9,32'hecdb8fca,32'hb9d465ee},
    {32'h1c30bf84,32'hd4b7cd64,32'h5b2a404f,32'had037e33},
    {32'hb2cc0bb9,32'h941723bf,32'h69028b2e,32'h8df69800},
    {32'hfa0478a6,32'hde6f5572,32'h4aaa9ec8,32'h5c9d2d8a},
    {32'hdfb49f2b,32'h6b772a12,32'h0efa4f2e,32'h29129fd4},
    {32'h1ea10344,32'hf449a236,32'h32d611ae,32'hbb6a12ee},
    {32'haf044988,32'h4b050084,32'h5f9600c9,32'h9ca8eca6},
    {32'h21025ed8,32'h9d199c4f,32'h78a2c7e3,32'h27e593ec},
    {32'hbf3aaaf8,32'ha759c9b7,32'hb9282ecd,32'h82d40173},
    {32'h6260700d,32'h6186b017,32'h37f2efd9,32'h10307d6b},
    {32'h5aca45c2,32'h21300443,32'h81c29153,32'hf6fc9ac6},
    {32'h9223973c,32'h226b68bb,32'h2caf92e8,32'h36d1943a},
    {32'hd3bf9238,32'h225886eb,32'h6cbab958,32'he51071b4},
    {32'hdb863ce5,32'haef0c677,32'h933dfddd,32'h24e1128d},
    {32'hbb606268,32'hffeba09c,32'h83e48de3,32'hcb2212b1},
    {32'h734bd3dc,32'he2e4d19c,32'h2db91a4e,32'hc72bf77d},
    {32'h43bb47c3,32'h61301b43,32'h4b1415c4,32'h2cb3924e},
    {32'hdba775a8,32'he707eff6,32'h03b231dd,32'h16eb6899},
    {32'h6df3614b,32'h3c755977,32'h8e5e2302,32'h7eca472c},
    {32'hcda75a17,32'hd6de7d77,32'h6d1be5b9,32'hb88617f9},
    {32'hec6b43f0,32'h6ba8e9aa,32'h9d6c069d,32'ha946ee5d},
    {32'hcb1e6950,32'hf957332b,32'ha2531159,32'h3bf327c1},
    {32'h2cee0c75,32'h00da619c,32'he4ed0353,32'h600ed0d9},
    {32'hf0b1a5a1,32'h96e90cab,32'h80bbbabc,32'h63a4a350},
    {32'hae3db102,32'h5e962988,32'hab0dde30,32'h938dca39},
    {32'h17bb8f38,32'hd554a40b,32'h8814f3a8,32'h2e75b442},
    {32'h34bb8a5b,32'h5f427fd7,32'haeb6b779,32'h360a16f6},
    {32'h26f65241,32'hcbe55438,32'h43ce5918,32'hffbaafde},
    {32'h4ce99a54,32'hb9f3026a,32'ha2ca9cf7,32'h839ec978},
    {32'hae51a51a,32'h1bdff7be,32'h40c06e28,32'h22901235},
    {32'ha0c1613c,32'hba7ed22b,32'hc173bc0f,32'h48a659cf},
    {32'h756acc03,32'h02288288,32'h4ad6bdfd,32'he9c59da1}
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES encryption round; byte n of the state in bits 8n+7:8n.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = Sbox[s[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      o[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    aes_round = o ^ k;
  endfunction

  // Dword interleave: low half a0 b0 a1 b1, high half a2 b2 a3 b3.
  function automatic logic [127:0] interleave(input logic [127:0] a, input logic [127:0] b,
                                              input logic high);
    logic [63:0] ah, bh;
    ah = high ? a[127:64] : a[63:0];
    bh = high ? b[127:64] : b[63:0];
    interleave = {bh[63:32], ah[63:32], bh[31:0], ah[31:0]};
  endfunction

endpackage

FILE: design/hhch_ctrl.sv
// Controller: word position tracking and compression sequencing.
module hhch_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     frame_start,
  output logic                     in_ready,
  input  logic                     out_full,
  output hhch_pkg::dp_cmd_t        cmd
);

  hhch_pkg::ctrl_state_t state, state_next;
  logic [hhch_pkg::PosW-1:0]  word_position;
  logic [hhch_pkg::PosW-1:0]  pos;
  logic [hhch_pkg::PassW-1:0] pass_cnt;
  logic                       accept;
  logic                       chunk_end;

  always_comb begin
    pos = frame_start ? '0 : word_position;
    if (pos >= hhch_pkg::PosW'(hhch_pkg::NWords)) pos = '0;
  end

  assign in_ready  = (state == hhch_pkg::ST_LOAD) && !out_full;
  assign accept    = in_valid && in_ready;
  assign chunk_end = (pos == hhch_pkg::PosW'(hhch_pkg::NWords - 1)) || (pos[3:0] == 4'hf);

  always_comb begin
    state_next = state;
    case (state)
      hhch_pkg::ST_LOAD: begin
        if (accept && chunk_end) state_next = hhch_pkg::ST_ROUND;
      end
      hhch_pkg::ST_ROUND: begin
        if (pass_cnt == hhch_pkg::PassW'(hhch_pkg::PassCount - 1)) begin
          state_next = hhch_pkg::ST_FINISH;
        end
      end
      hhch_pkg::ST_FINISH: state_next = hhch_pkg::ST_LOAD;
      default: state_next = hhch_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.pos        = pos;
    cmd.pass_idx   = pass_cnt;
    cmd.load_word  = accept;
    cmd.start_comp = accept && chunk_end;
    cmd.do_pass    = (state == hhch_pkg::ST_ROUND);
    cmd.finish     = (state == hhch_pkg::ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hhch_pkg::ST_LOAD;
      word_position <= '0;
      pass_cnt      <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        word_position <= (pos == hhch_pkg::PosW'(hhch_pkg::NWords - 1)) ? '0 : pos + 1'b1;
      end
      if (state == hhch_pkg::ST_ROUND) pass_cnt <= pass_cnt + 1'b1;
      else pass_cnt <= '0;
    end
  end

endmodule

FILE: design/hhch_dp.sv
// Datapath: chunk buffer, chain value, key store, lane rounds and target compare.
module hhch_dp (
  input  logic              clk,
  input  logic [31:0]       header_word,
  input  hhch_pkg::dp_cmd_t cmd,
  input  logic [255:0]      target,
  output logic [255:0]      hash,
  output logic              below
);

  logic [511:0] chunk_buffer;
  logic [255:0] chain_value;
  logic [255:0] key_store;
  logic [511:0] lane_state;
  logic [511:0] comp_in;
  logic         keyed;
  logic [511:0] blk_next;
  logic [511:0] lanes_next;
  logic [127:0] k0;
  logic [127:0] l0, l1, l2, l3, t0, n0, n1, n2;
  logic [3:0]   rnd;
  logic         second;
  logic [255:0] h;
  logic         lt;
  logic         decided;
  logic [7:0]   hb, tb;

  // Build the chunk including the current word.
  always_comb begin
    logic [7:0] v;
    blk_next = (cmd.pos[3:0] == 4'h0) ? '0 : chunk_buffer;
    for (int b = 0; b < 4; b++) begin
      v = ((int'(cmd.pos) * 4 + b) < hhch_pkg::HeaderBytes) ? header_word[8*b +: 8] : 8'h00;
      blk_next[8*(int'(cmd.pos[3:0]) * 4 + b) +: 8] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      chunk_buffer <= blk_next;
      for (int b = 0; b < 4; b++) begin
        if ((int'(cmd.pos) * 4 + b) >= hhch_pkg::KeyFirst &&
            (int'(cmd.pos) * 4 + b) < hhch_pkg::KeyEnd) begin
          key_store[8*(int'(cmd.pos) * 4 + b - hhch_pkg::KeyFirst) +: 8] <=
            ((int'(cmd.pos) * 4 + b) < hhch_pkg::HeaderBytes) ? header_word[8*b +: 8] : 8'h00;
        end
      end
    end
  end

  // One pass: one AES round on each of four lanes; mix after every second pass.
  assign rnd    = {1'b0, cmd.pass_idx[3:1]};
  assign second = cmd.pass_idx[0];

  always_comb begin
    k0 = hhch_pkg::Ktab[6'(rnd * 8 + second * 4)];
    if (keyed) k0 = k0 ^ (second ? key_store[255:128] : key_store[127:0]);
    l0 = hhch_pkg::aes_round(lane_state[127:0], k0);
    l1 = hhch_pkg::aes_round(lane_state[255:128], hhch_pkg::Ktab[6'(rnd * 8 + second * 4 + 1)]);
    l2 = hhch_pkg::aes_round(lane_state[383:256], hhch_pkg::Ktab[6'(rnd * 8 + second * 4 + 2)]);
    l3 = hhch_pkg::aes_round(lane_state[511:384], hhch_pkg::Ktab[6'(rnd * 8 + second * 4 + 3)]);
    t0 = hhch_pkg::interleave(l0, l1, 1'b0);
    n0 = hhch_pkg::interleave(l0, l1, 1'b1);
    n1 = hhch_pkg::interleave(l2, l3, 1'b0);
    n2 = hhch_pkg::interleave(l2, l3, 1'b1);
    if (second) begin
      lanes_next = {hhch_pkg::interleave(n0, n2, 1'b0), hhch_pkg::interleave(n1, t0, 1'b1),
                    hhch_pkg::interleave(n1, t0, 1'b0), hhch_pkg::interleave(n0, n2, 1'b1)};
    end else begin
      lanes_next = {l3, l2, l1, l0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_comp) begin
      comp_in    <= (cmd.pos >= 6'd16) ? (blk_next ^ {256'd0, chain_value}) : blk_next;
      lane_state <= (cmd.pos >= 6'd16) ? (blk_next ^ {256'd0, chain_value}) : blk_next;
      keyed      <= (cmd.pos == hhch_pkg::PosW'(hhch_pkg::NWords - 1));
    end else if (cmd.do_pass) begin
      lane_state <= lanes_next;
    end
  end

  assign h = {lane_state[383:256] ^ comp_in[383:256], lane_state[127:0] ^ comp_in[127:0]};

  always_ff @(posedge clk) begin
    if (cmd.finish) chain_value <= h;
  end

  // Compare a byte at a time from byte 0; the first difference decides.
  always_comb begin
    lt = 1'b0;
    decided = 1'b0;
    for (int i = 0; i < 32; i++) begin
      hb = h[8*i +: 8];
      tb = target[8*i +: 8];
      if (!decided && hb != tb) begin
        lt = hb < tb;
        decided = 1'b1;
      end
    end
  end

  assign hash  = h;
  assign below = lt;

endmodule

FILE: design/haraka512_header_chain_hash.sv
// Top level: chained Haraka-512 header hash with a below-target flag.
// The last header word starts the final compression, whose lane passes and finish step
// precede the result. Throughput: one word per cycle while loading, if the output is not
// stalled; input waits while the single four-lane AES round unit works a 64-byte chunk.
// Reset (rst, synchronous) clears the sequencer, word position, targets and output valid.
module haraka512_header_chain_hash (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // header_word[31:0]
  input  logic         s_axis_tuser,   // frame_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata,   // hash_word0..3, below_target, zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  hhch_pkg::dp_cmd_t cmd;
  logic [255:0] target;
  logic [255:0] hash;
  logic         below;
  logic         last_comp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_valid) begin
      target[64*cfg_index +: 64] <= cfg_data;
    end
  end

  hhch_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .frame_start (s_axis_tuser),
    .in_ready    (s_axis_tready),
    .out_full    (m_axis_tvalid && !m_axis_tready),
    .cmd         (cmd)
  );

  hhch_dp u_dp (
    .clk         (clk),
    .header_word (s_axis_tdata),
    .cmd         (cmd),
    .target      (target),
    .hash        (hash),
    .below       (below)
  );

  // Track whether the running compression is the last of a header.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_comp <= 1'b0;
    end else if (cmd.start_comp) begin
      last_comp <= (cmd.pos == hhch_pkg::PosW'(hhch_pkg::NWords - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish && last_comp) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last_comp) m_axis_tdata <= {7'd0, below, hash};
  end

endmodule
